[hdl/tpsc_pkg.sv]
// Shared types and constants for the two-point sensor calibration block.
package tpsc_pkg;

  // Fixed-point fraction bits of the calibrated outputs
  localparam int FRACTION_BITS = 6;
  // Calibration y values: temperature is in 1/8 degC, humidity in 1/2 percent
  localparam int TEMP_SHIFT    = FRACTION_BITS - 3;
  localparam int HUM_SHIFT     = FRACTION_BITS - 1;

  localparam int XW    = 16;                  // raw sample width
  localparam int DXW   = XW + 1;              // raw difference width
  localparam int YW    = FRACTION_BITS + 8;   // fixed-point y, signed
  localparam int DYW   = YW + 1;              // y difference width
  localparam int PW    = DYW + DXW;           // product width
  localparam int QW    = FRACTION_BITS + 24;  // bound on product magnitude
  localparam int BPS   = 4;                   // quotient bits per divider stage
  localparam int NST   = (QW + BPS - 1) / BPS;
  localparam int QP    = NST * BPS;           // padded quotient width
  localparam int DW    = DXW;                 // divisor magnitude width
  localparam int RW    = DW + 1;              // partial remainder width
  localparam int SUMW  = QP + 2;              // final sum width
  localparam int LANE_LAT = NST + 2;          // register stages inside a lane
  localparam int OUTW  = 16;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EQUAL = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_T_X0 = 3'd0,
    REG_T_X1 = 3'd1,
    REG_T_Y0 = 3'd2,
    REG_T_Y1 = 3'd3,
    REG_H_X0 = 3'd4,
    REG_H_X1 = 3'd5,
    REG_H_Y0 = 3'd6,
    REG_H_Y1 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [XW-1:0] raw_temperature;
    logic signed [XW-1:0] raw_humidity;
  } in_word_t;

  typedef struct packed {
    logic signed [OUTW-1:0] temperature_q6;
    logic signed [OUTW-1:0] humidity_q6;
    logic [1:0]             temperature_status;
    logic [1:0]             humidity_status;
  } out_word_t;

  // Calibration line of one lane
  typedef struct packed {
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] x1;
    logic signed [YW-1:0] y0;
    logic signed [YW-1:0] y1;
  } lane_cfg_t;

  // Result of one lane
  typedef struct packed {
    logic signed [OUTW-1:0] value;
    status_e                status;
  } lane_res_t;

endpackage

[hdl/tpsc_lane.sv]
// One calibration lane: multiply, pipelined divide, offset add and saturation.
module tpsc_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [tpsc_pkg::XW-1:0]      x_i,
  input  tpsc_pkg::lane_cfg_t                 cfg_i,
  output tpsc_pkg::lane_res_t                 res_o
);

  typedef struct packed {
    logic [tpsc_pkg::RW-1:0] rem;
    logic [tpsc_pkg::QP-1:0] num;
    logic [tpsc_pkg::QP-1:0] quo;
  } div_t;

  localparam logic signed [tpsc_pkg::SUMW-1:0] SAT_HI = tpsc_pkg::SUMW'(32'sd32767);
  localparam logic signed [tpsc_pkg::SUMW-1:0] SAT_LO = tpsc_pkg::SUMW'(-32'sd32768);

  // BPS restoring division steps on magnitudes
  function automatic div_t div_step(input div_t s, input logic [tpsc_pkg::DW-1:0] d);
    div_t r;
    r = s;
    for (int b = 0; b < tpsc_pkg::BPS; b++) begin
      r.rem = {r.rem[tpsc_pkg::RW-2:0], r.num[tpsc_pkg::QP-1]};
      r.num = {r.num[tpsc_pkg::QP-2:0], 1'b0};
      if (r.rem >= {1'b0, d}) begin
        r.rem = r.rem - {1'b0, d};
        r.quo = {r.quo[tpsc_pkg::QP-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[tpsc_pkg::QP-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic signed [tpsc_pkg::DYW-1:0] dy_d, dy_q;
  logic signed [tpsc_pkg::DXW-1:0] dx_d, dx_q;
  logic signed [tpsc_pkg::PW-1:0]  prod_d, prod_q;
  logic signed [tpsc_pkg::DXW-1:0] den;
  logic                            den_zero;
  logic [tpsc_pkg::DW-1:0]         dmag;
  logic [tpsc_pkg::PW-1:0]         pmag;
  logic                            neg0;
  div_t                            div_in [tpsc_pkg::NST];
  div_t                            div_q  [tpsc_pkg::NST];
  logic                            neg_q  [tpsc_pkg::NST];
  logic signed [tpsc_pkg::SUMW-1:0] qs;
  logic signed [tpsc_pkg::SUMW-1:0] sum;

  // Anchor deltas; the user keeps config static while words fly; not enforced
  assign dy_d = tpsc_pkg::DYW'(cfg_i.y1) - tpsc_pkg::DYW'(cfg_i.y0);
  assign dx_d = tpsc_pkg::DXW'(x_i) - tpsc_pkg::DXW'(cfg_i.x1);
  assign den  = tpsc_pkg::DXW'(cfg_i.x1) - tpsc_pkg::DXW'(cfg_i.x0);
  assign den_zero = (den == '0);
  assign dmag = den[tpsc_pkg::DXW-1] ? tpsc_pkg::DW'(-den) : tpsc_pkg::DW'(den);

  assign prod_d = tpsc_pkg::PW'(dy_q) * tpsc_pkg::PW'(dx_q);

  // Sign and magnitude into the divider
  assign pmag = prod_q[tpsc_pkg::PW-1] ? tpsc_pkg::PW'(-prod_q) : tpsc_pkg::PW'(prod_q);
  assign neg0 = prod_q[tpsc_pkg::PW-1] ^ den[tpsc_pkg::DXW-1];

  always_comb begin
    div_in[0].rem = '0;
    div_in[0].num = tpsc_pkg::QP'(pmag);
    div_in[0].quo = '0;
    for (int k = 1; k < tpsc_pkg::NST; k++) begin
      div_in[k] = div_q[k-1];
    end
  end

  // Multiplier and divider stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dy_q   <= dy_d;
      dx_q   <= dx_d;
      prod_q <= prod_d;
      neg_q[0] <= neg0;
      for (int k = 0; k < tpsc_pkg::NST; k++) begin
        div_q[k] <= div_step(div_in[k], dmag);
      end
      for (int k = 1; k < tpsc_pkg::NST; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Signed quotient plus anchor, then saturation
  assign qs  = neg_q[tpsc_pkg::NST-1]
             ? -$signed(tpsc_pkg::SUMW'(div_q[tpsc_pkg::NST-1].quo))
             :  $signed(tpsc_pkg::SUMW'(div_q[tpsc_pkg::NST-1].quo));
  assign sum = qs + tpsc_pkg::SUMW'(cfg_i.y1);

  always_comb begin
    if (den_zero) begin
      res_o.value  = '0;
      res_o.status = tpsc_pkg::ST_EQUAL;
    end else if (sum > SAT_HI) begin
      res_o.value  = 16'sh7fff;
      res_o.status = tpsc_pkg::ST_SAT;
    end else if (sum < SAT_LO) begin
      res_o.value  = -16'sh8000;
      res_o.status = tpsc_pkg::ST_SAT;
    end else begin
      res_o.value  = sum[tpsc_pkg::OUTW-1:0];
      res_o.status = tpsc_pkg::ST_OK;
    end
  end

endmodule

[hdl/two_point_sensor_calibration.sv]
// An accepted input word passes the LANE_LAT register stages of a lane, then the output register.
// Throughput: one word per cycle while the output is not stalled; each lane has a 4-bit-per-stage pipelined divider.
// Temperature and humidity run in two parallel lanes merged into one output register.
// The pipeline advances whenever the output register is empty or being taken.
// Reset (async, active low) clears all calibration registers and valid flags.
module two_point_sensor_calibration (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpsc_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpsc_pkg::out_word_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  logic signed [15:0] t_x0_q, t_x1_q, h_x0_q, h_x1_q;
  logic [9:0]         t_y0_q, t_y1_q;
  logic [7:0]         h_y0_q, h_y1_q;
  tpsc_pkg::lane_cfg_t t_cfg, h_cfg;
  tpsc_pkg::lane_res_t t_res, h_res;
  logic [tpsc_pkg::LANE_LAT-1:0] vld_q;
  logic                advance;
  logic                out_valid_q;
  tpsc_pkg::out_word_t out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_x0_q <= '0;
      t_x1_q <= '0;
      t_y0_q <= '0;
      t_y1_q <= '0;
      h_x0_q <= '0;
      h_x1_q <= '0;
      h_y0_q <= '0;
      h_y1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tpsc_pkg::reg_idx_e'(cfg_idx_i))
        tpsc_pkg::REG_T_X0: t_x0_q <= cfg_wdata_i;
        tpsc_pkg::REG_T_X1: t_x1_q <= cfg_wdata_i;
        tpsc_pkg::REG_T_Y0: t_y0_q <= cfg_wdata_i[9:0];
        tpsc_pkg::REG_T_Y1: t_y1_q <= cfg_wdata_i[9:0];
        tpsc_pkg::REG_H_X0: h_x0_q <= cfg_wdata_i;
        tpsc_pkg::REG_H_X1: h_x1_q <= cfg_wdata_i;
        tpsc_pkg::REG_H_Y0: h_y0_q <= cfg_wdata_i[7:0];
        tpsc_pkg::REG_H_Y1: h_y1_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Calibration points scaled to output fixed point
  always_comb begin
    t_cfg.x0 = t_x0_q;
    t_cfg.x1 = t_x1_q;
    t_cfg.y0 = tpsc_pkg::YW'(t_y0_q) << tpsc_pkg::TEMP_SHIFT;
    t_cfg.y1 = tpsc_pkg::YW'(t_y1_q) << tpsc_pkg::TEMP_SHIFT;
    h_cfg.x0 = h_x0_q;
    h_cfg.x1 = h_x1_q;
    h_cfg.y0 = tpsc_pkg::YW'(h_y0_q) << tpsc_pkg::HUM_SHIFT;
    h_cfg.y1 = tpsc_pkg::YW'(h_y1_q) << tpsc_pkg::HUM_SHIFT;
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  tpsc_lane u_temp_lane (
    .clk_i (clk_i),
    .en_i  (advance),
    .x_i   (in_data_i.raw_temperature),
    .cfg_i (t_cfg),
    .res_o (t_res)
  );

  tpsc_lane u_hum_lane (
    .clk_i (clk_i),
    .en_i  (advance),
    .x_i   (in_data_i.raw_humidity),
    .cfg_i (h_cfg),
    .res_o (h_res)
  );

  // Valid flags follow the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vld_q       <= {vld_q[tpsc_pkg::LANE_LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[tpsc_pkg::LANE_LAT-1];
    end
  end

  // Merge both lanes into the output word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.temperature_q6     <= t_res.value;
      out_q.humidity_q6        <= h_res.value;
      out_q.temperature_status <= t_res.status;
      out_q.humidity_status    <= h_res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q))
    else $error("valid flags moved during stall");

  a_equal_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.temperature_status == tpsc_pkg::ST_EQUAL)
      |-> (out_data_o.temperature_q6 == '0))
    else $error("equal points but nonzero temperature");

  a_hum_equal_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.humidity_status == tpsc_pkg::ST_EQUAL)
      |-> (out_data_o.humidity_q6 == '0))
    else $error("equal points but nonzero humidity");

  a_sat_is_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.temperature_status == tpsc_pkg::ST_SAT)
      |-> (out_data_o.temperature_q6 == 16'sh7fff
           || out_data_o.temperature_q6 == -16'sh8000))
    else $error("saturated temperature not at a rail");

endmodule

[sim/tb.sv]
// Self-checking testbench for the two-point sensor calibration block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = tpsc_pkg::LANE_LAT + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 135;
  localparam int N_ROWS      = 16;

  // Directed row: calibration set, raw inputs, optional typed-in result
  typedef struct packed {
    logic [1:0]          set;
    logic signed [15:0]  t;
    logic signed [15:0]  h;
    logic                has_exp;
    tpsc_pkg::out_word_t exp;
  } dir_row_t;

  // Register values of the directed calibration sets, by register index
  localparam logic [15:0] CAL_SETS [4][8] = '{
    '{16'h0000, 16'h0000, 16'd0, 16'd0, 16'h0000, 16'h0000, 16'd0, 16'd0},
    '{16'h8000, 16'h7fff, 16'd0, 16'd1023, 16'h7fff, 16'h8000, 16'd255, 16'd0},
    '{16'h0000, 16'h0001, 16'd0, 16'd1023, 16'h0001, 16'h0000, 16'd255, 16'd0},
    '{16'd1234, 16'd1234, 16'd77, 16'd900, 16'hf000, 16'hf000, 16'd3, 16'd250}
  };

  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    // after reset: both channels have equal points
    '{2'd0, 16'sh0000, 16'sh0000, 1'b1,
      '{16'sd0, 16'sd0, tpsc_pkg::ST_EQUAL, tpsc_pkg::ST_EQUAL}},
    '{2'd0, 16'sh7fff, 16'sh8000, 1'b1,
      '{16'sd0, 16'sd0, tpsc_pkg::ST_EQUAL, tpsc_pkg::ST_EQUAL}},
    // widest spans: points map exactly onto their y values
    '{2'd1, 16'sh7fff, 16'sh8000, 1'b1,
      '{16'sd8184, 16'sd0, tpsc_pkg::ST_OK, tpsc_pkg::ST_OK}},
    '{2'd1, 16'sh8000, 16'sh7fff, 1'b1,
      '{16'sd0, 16'sd8160, tpsc_pkg::ST_OK, tpsc_pkg::ST_OK}},
    '{2'd1, 16'sh0000, 16'sh0000, 1'b0, '0},
    '{2'd1, 16'shffff, 16'sh0001, 1'b0, '0},
    '{2'd1, 16'sh5555, 16'shaaaa, 1'b0, '0},
    // steep lines: saturation at both ends
    '{2'd2, 16'sh7fff, 16'sh7fff, 1'b1,
      '{16'sh7fff, 16'sh7fff, tpsc_pkg::ST_SAT, tpsc_pkg::ST_SAT}},
    '{2'd2, 16'sh8000, 16'sh8000, 1'b1,
      '{16'sh8000, 16'sh8000, tpsc_pkg::ST_SAT, tpsc_pkg::ST_SAT}},
    '{2'd2, 16'sh0001, 16'sh0000, 1'b0, '0},
    '{2'd2, 16'sh0002, 16'shffff, 1'b0, '0},
    '{2'd2, 16'sh0005, 16'shfffc, 1'b0, '0},
    // equal points carrying nonzero y values
    '{2'd3, 16'sd1234, 16'shf000, 1'b0, '0},
    '{2'd3, 16'sh7fff, 16'sh8000, 1'b0, '0},
    '{2'd3, 16'sh0000, 16'sh1234, 1'b0, '0},
    '{2'd3, 16'sh8000, 16'sh7fff, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  tpsc_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tpsc_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [2:0]          cfg_idx;
  logic [15:0]         cfg_wdata;

  two_point_sensor_calibration uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  logic [15:0]         cal_reg [8];        // shadow of the calibration registers
  tpsc_pkg::out_word_t expected_words [$];
  int                  n_errors;
  int                  n_sent;
  int                  n_checked;
  int                  n_sat;
  int                  n_equal;
  int                  burst_left;
  int                  cycles;
  bit                  hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // One channel of the interpolation
  function automatic void interp_lane(longint x, longint x0, longint x1, longint y0,
                                      longint y1, output logic [15:0] v,
                                      output tpsc_pkg::status_e s);
    longint den;
    longint r;
    den = x1 - x0;
    if (den == 0) begin
      v = '0;
      s = tpsc_pkg::ST_EQUAL;
    end else begin
      r = y1 + ((y1 - y0) * (x - x1)) / den;
      s = tpsc_pkg::ST_OK;
      if (r > 32767) begin
        r = 32767;
        s = tpsc_pkg::ST_SAT;
      end else if (r < -32768) begin
        r = -32768;
        s = tpsc_pkg::ST_SAT;
      end
      v = r[15:0];
    end
  endfunction

  function automatic tpsc_pkg::out_word_t calibrate_word(tpsc_pkg::in_word_t w);
    tpsc_pkg::out_word_t o;
    logic [15:0]         v;
    tpsc_pkg::status_e   s;
    interp_lane(longint'(w.raw_temperature),
                longint'($signed(cal_reg[tpsc_pkg::REG_T_X0])),
                longint'($signed(cal_reg[tpsc_pkg::REG_T_X1])),
                longint'(cal_reg[tpsc_pkg::REG_T_Y0]) << tpsc_pkg::TEMP_SHIFT,
                longint'(cal_reg[tpsc_pkg::REG_T_Y1]) << tpsc_pkg::TEMP_SHIFT, v, s);
    o.temperature_q6     = v;
    o.temperature_status = s;
    interp_lane(longint'(w.raw_humidity),
                longint'($signed(cal_reg[tpsc_pkg::REG_H_X0])),
                longint'($signed(cal_reg[tpsc_pkg::REG_H_X1])),
                longint'(cal_reg[tpsc_pkg::REG_H_Y0]) << tpsc_pkg::HUM_SHIFT,
                longint'(cal_reg[tpsc_pkg::REG_H_Y1]) << tpsc_pkg::HUM_SHIFT, v, s);
    o.humidity_q6     = v;
    o.humidity_status = s;
    return o;
  endfunction

  // Let the pipeline drain fully before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  // Write all eight registers, one per cycle; shadow keeps only the register width
  task automatic write_cal(logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= tpsc_pkg::reg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      case (tpsc_pkg::reg_idx_e'(i)) inside
        tpsc_pkg::REG_T_Y0, tpsc_pkg::REG_T_Y1: cal_reg[i] = vals[i] & 16'h03ff;
        tpsc_pkg::REG_H_Y0, tpsc_pkg::REG_H_Y1: cal_reg[i] = vals[i] & 16'h00ff;
        default:                                cal_reg[i] = vals[i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one word in bursts; queue the expectation at acceptance
  task automatic send_word(tpsc_pkg::in_word_t w, bit has_exp, tpsc_pkg::out_word_t exp,
                           bit no_gap);
    int gap;
    if (burst_left == 0 && !no_gap) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    expected_words.push_back(has_exp ? exp : calibrate_word(w));
    n_sent++;
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random calibration set of a given flavor; y registers carry junk upper bits
  task automatic random_cal(int kind);
    logic [15:0] vals [8];
    for (int i = 0; i < 8; i++) vals[i] = 16'($urandom);
    case (kind)
      1: vals[tpsc_pkg::REG_T_X1] = vals[tpsc_pkg::REG_T_X0];
      2: vals[tpsc_pkg::REG_H_X1] = vals[tpsc_pkg::REG_H_X0];
      3: begin
        vals[tpsc_pkg::REG_T_X1] = vals[tpsc_pkg::REG_T_X0] + 16'($urandom_range(1, 3));
        vals[tpsc_pkg::REG_H_X1] = vals[tpsc_pkg::REG_H_X0] - 16'($urandom_range(1, 3));
      end
      4: begin
        vals[tpsc_pkg::REG_T_X0] = 16'h8000;
        vals[tpsc_pkg::REG_T_X1] = 16'h7fff;
        vals[tpsc_pkg::REG_T_Y0] = 16'hffff;
        vals[tpsc_pkg::REG_T_Y1] = 16'h0000;
        vals[tpsc_pkg::REG_H_X0] = 16'h7fff;
        vals[tpsc_pkg::REG_H_X1] = 16'h8000;
        vals[tpsc_pkg::REG_H_Y0] = 16'h0000;
        vals[tpsc_pkg::REG_H_Y1] = 16'hffff;
      end
      default: ;
    endcase
    write_cal(vals);
  endtask

  // Receiver: runs of always-ready, random and mostly-stalled, plus a long hold
  initial begin
    int run_left;
    int mode;
    out_ready <= 1'b0;
    run_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(5, 60);
        end
        run_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    tpsc_pkg::out_word_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, out_data);
        n_errors++;
      end else begin
        e = expected_words.pop_front();
        n_checked++;
        if (out_data.temperature_status == tpsc_pkg::ST_SAT
            || out_data.humidity_status == tpsc_pkg::ST_SAT)
          n_sat++;
        if (out_data.temperature_status == tpsc_pkg::ST_EQUAL
            || out_data.humidity_status == tpsc_pkg::ST_EQUAL)
          n_equal++;
        if (out_data.temperature_q6 !== e.temperature_q6) begin
          $display("%0t: temperature_q6 expected %0d got %0d", $time,
                   e.temperature_q6, out_data.temperature_q6);
          n_errors++;
        end
        if (out_data.humidity_q6 !== e.humidity_q6) begin
          $display("%0t: humidity_q6 expected %0d got %0d", $time,
                   e.humidity_q6, out_data.humidity_q6);
          n_errors++;
        end
        if (out_data.temperature_status !== e.temperature_status) begin
          $display("%0t: temperature_status expected %0d got %0d", $time,
                   e.temperature_status, out_data.temperature_status);
          n_errors++;
        end
        if (out_data.humidity_status !== e.humidity_status) begin
          $display("%0t: humidity_status expected %0d got %0d", $time,
                   e.humidity_status, out_data.humidity_status);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    tpsc_pkg::in_word_t  w;
    tpsc_pkg::out_word_t none;
    logic [1:0]          cur_set;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    cycles    <= 0;
    hold_req  = 1'b0;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_sat     = 0;
    n_equal   = 0;
    burst_left = 0;
    none      = '0;
    for (int i = 0; i < 8; i++) cal_reg[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; first set is the reset state
    cur_set = 2'd0;
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIR_ROWS[r].set != cur_set) begin
        wait_idle();
        cur_set = DIR_ROWS[r].set;
        write_cal(CAL_SETS[cur_set]);
      end
      w.raw_temperature = DIR_ROWS[r].t;
      w.raw_humidity    = DIR_ROWS[r].h;
      send_word(w, DIR_ROWS[r].has_exp, DIR_ROWS[r].exp, 1'b0);
    end

    // Random phases, each under its own calibration set
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      random_cal(p < 5 ? p : $urandom_range(0, 4));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // long receiver hold while the sender keeps offering
        if (p == 2 && k == 10) hold_req = 1'b1;
        // sender pause until every result is back
        if (p == 4 && k == 60) begin
          in_valid <= 1'b0;
          while (expected_words.size() != 0) @(posedge clk_i);
        end
        w.raw_temperature = rand_raw();
        w.raw_humidity    = rand_raw();
        send_word(w, 1'b0, none, p == 2 && k >= 10 && k < 110);
      end
    end

    wait_idle();
    repeat (PIPE_LAT * 2) @(posedge clk_i);
    $display("Sent %0d words over %0d calibration sets; %0d checked,", n_sent,
             N_PHASES + 4, n_checked);
    $display("  %0d with a saturated channel, %0d with equal points.", n_sat, n_equal);
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
